// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/sitdt_pkg.sv =====
// ----------------------------------------------------------------------------
// sitdt_pkg
// Shared widths, character codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sitdt_pkg;

  localparam int BIN_W     = 32;
  localparam int NUM_DIG   = 10;
  localparam int DIG_W     = 4;
  localparam int BCD_W     = NUM_DIG * DIG_W;
  localparam int CHAR_W    = 7;
  localparam int CNT_W     = $clog2(BIN_W);
  localparam int REM_W     = $clog2(NUM_DIG + 1);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

  typedef struct packed {
    logic load;
    logic shift;
    logic skip;
    logic emit_sign;
    logic emit_digit;
    logic last;
  } sitdt_cmd_t;

  typedef struct packed {
    logic top_zero;
    logic neg;
    logic out_free;
  } sitdt_status_t;

endpackage

// ===== rtl/signed_int_to_decimal_text_core.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text_core
// Renders one signed 32-bit integer as decimal ASCII, one character per beat.
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | in_valid, in_ready, in_number[31:0]    | in
//  result  | out_valid, out_ready, out_text_char,   | out
//          | out_last_char                          |
//
//  A number goes through a load step, the shift-add-3 steps of the
//  bit-serial BCD converter, the leading-zero skips and an exit from the
//  skip state, then the character beats. Skips and digits always sum to
//  ten; a negative value adds a sign beat before the digits.
//  in_ready is high only between numbers; an unaccepted character holds the sequencer before its next one.
//  rst_n is synchronous and active low; it clears the sequencer and out_valid.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [sitdt_pkg::BIN_W-1:0] in_number,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sitdt_pkg::CHAR_W-1:0]     out_text_char,
  output logic                             out_last_char
);
  import sitdt_pkg::*;

  sitdt_cmd_t    cmd;
  sitdt_status_t status;

  sitdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sitdt_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_number     (in_number),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

endmodule

// ===== rtl/sitdt_datapath.sv =====
// ----------------------------------------------------------------------------
// sitdt_datapath
// Magnitude and BCD registers with a shift-add-3 step, digit shifter and
// output register for the character beats.
// ----------------------------------------------------------------------------
module sitdt_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic signed [sitdt_pkg::BIN_W-1:0] in_number,
  input  sitdt_pkg::sitdt_cmd_t          cmd,
  output sitdt_pkg::sitdt_status_t       status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sitdt_pkg::CHAR_W-1:0]   out_text_char,
  output logic                           out_last_char
);
  import sitdt_pkg::*;

  logic [BIN_W-1:0]  mag_r, mag_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt, bcd_adj;
  logic              neg_r, neg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;
  logic [BIN_W-1:0]  raw;
  logic [DIG_W-1:0]  top_dig;

  assign raw     = in_number;
  assign top_dig = bcd_r[BCD_W-1 -: DIG_W];

  always_comb begin
    for (int i = 0; i < NUM_DIG; i++) begin
      if (bcd_r[i*DIG_W +: DIG_W] >= DIG_W'(5)) begin
        bcd_adj[i*DIG_W +: DIG_W] = bcd_r[i*DIG_W +: DIG_W] + DIG_W'(3);
      end else begin
        bcd_adj[i*DIG_W +: DIG_W] = bcd_r[i*DIG_W +: DIG_W];
      end
    end
  end

  always_comb begin
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load) begin
      neg_nxt = raw[BIN_W-1];
      mag_nxt = raw[BIN_W-1] ? (BIN_W'(0) - raw) : raw;
      bcd_nxt = '0;
    end else if (cmd.shift) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[BIN_W-1]};
      mag_nxt = {mag_r[BIN_W-2:0], 1'b0};
    end else if (cmd.skip) begin
      bcd_nxt = {bcd_r[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
    end else if (cmd.emit_sign) begin
      out_valid_nxt = 1'b1;
      char_nxt      = CHAR_MINUS;
      last_nxt      = 1'b0;
    end else if (cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
      char_nxt      = CHAR_ZERO + CHAR_W'(top_dig);
      last_nxt      = cmd.last;
      bcd_nxt       = {bcd_r[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign status.top_zero = (top_dig == '0);
  assign status.neg      = neg_r;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_text_char = char_r;
  assign out_last_char = last_r;

endmodule

// ===== rtl/sitdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sitdt_ctrl
// Sequencer: load, 32 conversion steps, leading-zero skip, sign and digit
// beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sitdt_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sitdt_pkg::sitdt_status_t status,
  output sitdt_pkg::sitdt_cmd_t    cmd
);
  import sitdt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_DIG  = 3'd4;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BIN_W - 1);
  localparam logic [REM_W-1:0] REM_FULL = REM_W'(NUM_DIG);
  localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          rem_nxt   = REM_FULL;
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (status.top_zero && rem_r != REM_ONE) begin
          cmd.skip = 1'b1;
          rem_nxt  = rem_r - REM_ONE;
        end else begin
          state_nxt = status.neg ? S_SIGN : S_DIG;
        end
      end
      S_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = S_DIG;
        end
      end
      S_DIG: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          cmd.last       = (rem_r == REM_ONE);
          rem_nxt        = rem_r - REM_ONE;
          if (rem_r == REM_ONE) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
    end
  end

  `ASSERT_IMPL(a_emit_when_free, cmd.emit_digit || cmd.emit_sign, status.out_free)
  `ASSERT_IMPL(a_rem_live, state_r == S_DIG || state_r == S_SIGN, rem_r != '0)
  `ASSERT_NEXT(a_accept_starts_conv, in_valid && in_ready, state_r == S_CONV && cnt_r == '0)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks signed_int_to_decimal_text_core: random and corner numbers go in,
// the character beats that come out are compared with locally rendered text.
// ----------------------------------------------------------------------------
module testbench;
  import sitdt_pkg::*;

  localparam int unsigned RADIX = 10;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_PER_PHASE = 30;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
  } char_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [BIN_W-1:0] in_number = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CHAR_W-1:0] out_text_char;
  logic out_last_char;

  logic signed [BIN_W-1:0] pending_numbers[$];
  char_beat_t expected_chars[$];
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int mismatch_count = 0;
  int numbers_sent = 0;
  int chars_checked = 0;
  int negatives_sent = 0;

  signed_int_to_decimal_text_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Append the decimal text of one number to the expected characters.
  function automatic void render_decimal(input logic [BIN_W-1:0] raw);
    logic neg;
    logic [BIN_W-1:0] mag;
    logic [3:0] digits[NUM_DIG];
    int n_digits;
    char_beat_t beat;
    neg = raw[BIN_W-1];
    mag = neg ? (~raw + 1'b1) : raw;
    n_digits = 0;
    do begin
      digits[n_digits] = 4'(mag % RADIX);
      n_digits++;
      mag = mag / RADIX;
    end while (mag != 0 && n_digits < NUM_DIG);
    if (neg) begin
      beat.text_char = CHAR_MINUS;
      beat.last_char = 1'b0;
      expected_chars.push_back(beat);
    end
    for (int k = n_digits - 1; k >= 0; k--) begin
      beat.text_char = CHAR_ZERO + CHAR_W'(digits[k]);
      beat.last_char = (k == 0);
      expected_chars.push_back(beat);
    end
  endfunction

  function automatic logic signed [BIN_W-1:0] random_number();
    logic [BIN_W-1:0] v;
    case ($urandom_range(9))
      0: v = $urandom();
      1: begin
        v = 1;
        repeat ($urandom_range(9)) v = v * RADIX;
        v = v - $urandom_range(1);
        if ($urandom_range(1)) v = -v;
      end
      default: begin
        v = $urandom() >> $urandom_range(31);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  always @(posedge clk) begin : drive_numbers
    logic took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        render_decimal(in_number);
        numbers_sent++;
        if (in_number < 0) negatives_sent++;
      end
      if (!in_valid || took) begin
        if (pending_numbers.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_number <= pending_numbers.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_chars
    char_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected beat char=%0d last=%0b",
                                    out_text_char, out_last_char));
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (out_text_char !== want.text_char)
            report_mismatch($sformatf("text_char got %0d want %0d",
                                      out_text_char, want.text_char));
          if (out_last_char !== want.last_char)
            report_mismatch($sformatf("last_char got %0b want %0b",
                                      out_last_char, want.last_char));
        end
      end
    end
  end

  task automatic drain();
    while (pending_numbers.size() > 0 || in_valid || expected_chars.size() > 0)
      @(posedge clk);
  endtask

  task automatic run_random_phase(input int sender_pct, input int receiver_pct, input int count);
    sender_idle_pct = sender_pct;
    receiver_idle_pct = receiver_pct;
    repeat (count) pending_numbers.push_back(random_number());
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // corner values first
    sender_idle_pct = 21;
    receiver_idle_pct = 69;
    pending_numbers.push_back(0);
    pending_numbers.push_back(1);
    pending_numbers.push_back(-1);
    pending_numbers.push_back(9);
    pending_numbers.push_back(10);
    pending_numbers.push_back(-10);
    pending_numbers.push_back(99);
    pending_numbers.push_back(100);
    pending_numbers.push_back(32'sh7FFF_FFFF);
    pending_numbers.push_back(32'sh8000_0000);
    pending_numbers.push_back(32'sh8000_0001);
    pending_numbers.push_back(1000000000);
    pending_numbers.push_back(999999999);
    pending_numbers.push_back(-999999999);
    pending_numbers.push_back(-1000000000);
    pending_numbers.push_back(1234567890);
    pending_numbers.push_back(32'sh5555_5555);
    pending_numbers.push_back(32'shAAAA_AAAA);
    pending_numbers.push_back(7);
    pending_numbers.push_back(-5);
    pending_numbers.push_back(0);
    drain();

    run_random_phase(21, 69, RANDOM_PER_PHASE);
    run_random_phase(69, 21, RANDOM_PER_PHASE);
    run_random_phase(0, 0, RANDOM_PER_PHASE);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d numbers (%0d negative) and %0d character beats",
             numbers_sent, negatives_sent, chars_checked);
    $display("with sender and receiver stalls in both mixes and a no-stall stretch");
    if (mismatch_count == 0) begin
      $display("[signed_int_to_decimal_text_core] OK");
    end else begin
      $display("[signed_int_to_decimal_text_core] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout: %0d characters still expected", expected_chars.size());
    $display("[signed_int_to_decimal_text_core] ERROR");
    $finish;
  end

endmodule
